// ===== src/wc_range_register_allocator_top_macros.svh =====
// Assertion helpers shared by the allocator RTL.
// Each macro expects signals named clk and rst in the calling module.
`ifndef WC_RANGE_REGISTER_ALLOCATOR_TOP_MACROS_SVH
`define WC_RANGE_REGISTER_ALLOCATOR_TOP_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define WCRRA_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define WCRRA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define WCRRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/wcrra_pkg.sv =====
`default_nettype none

package wcrra_pkg;

  // Table depth default
  localparam int MAX_SLOTS_DEFAULT = 8;

  // Slot word encoding
  localparam logic [7:0]  WC_TYPE    = 8'h01;
  localparam int          VALID_POS  = 11;
  localparam logic [63:0] VALID_MASK = 64'd1 << VALID_POS;
  localparam logic [63:0] PAGE_LOW   = 64'hFFF;
  localparam int          PAGE_BITS  = 12;

  // Physical address width limits
  localparam logic [7:0] PHYS_MIN     = 8'd32;
  localparam logic [7:0] PHYS_MAX     = 8'd52;
  localparam logic [5:0] PHYS_DEFAULT = 6'd40;

  // Register reset values
  localparam logic [3:0] ACTIVE_SLOTS_RESET   = 4'd8;
  localparam logic       WC_SUPPORTED_RESET   = 1'b1;
  localparam logic [7:0] PHYS_ADDR_BITS_RESET = 8'd36;

  // Register indexes
  typedef enum logic [1:0] {
    CFG_ACTIVE_SLOTS   = 2'd0,
    CFG_WC_SUPPORTED   = 2'd1,
    CFG_PHYS_ADDR_BITS = 2'd2
  } cfg_index_t;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // Result status codes
  typedef enum logic [2:0] {
    STATUS_UNSUPPORTED = 3'd0,
    STATUS_MISALIGNED  = 3'd1,
    STATUS_COVERED     = 3'd2,
    STATUS_ADDED       = 3'd3,
    STATUS_NO_FREE     = 3'd4,
    STATUS_TOO_LARGE   = 3'd5,
    STATUS_WRITTEN     = 3'd6,
    STATUS_READ        = 3'd7
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_SCAN,
    ST_COMMIT,
    ST_WRITE,
    ST_READ,
    ST_READ_WAIT,
    ST_RESP
  } state_t;

  // Size round-up result: rounded size minus one
  typedef struct packed {
    logic        done;
    logic [63:0] szm1;
  } size_res_t;

endpackage

`default_nettype wire

// ===== src/wcrra_ram.sv =====
`default_nettype none

module wcrra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry through a register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/wcrra_size_unit.sv =====
`default_nettype none
`include "wc_range_register_allocator_top_macros.svh"

module wcrra_size_unit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [63:0]           size,
  output wcrra_pkg::size_res_t       res
);

  logic        v1, v2, v3;
  logic [63:0] d;
  logic [63:0] s2;
  logic [63:0] s3;
  logic [63:0] sa1, sa2, sa3;
  logic [63:0] sb1, sb2, sb3;

  // Advance the stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Smear the highest set bit of size minus one downward
  always_comb begin
    sa1 = d | (d >> 1);
    sa2 = sa1 | (sa1 >> 2);
    sa3 = sa2 | (sa2 >> 4);
    sb1 = s2 | (s2 >> 8);
    sb2 = sb1 | (sb1 >> 16);
    sb3 = sb2 | (sb2 >> 32);
  end

  // Hold the stage payloads; a zero size rounds up like a single page
  always_ff @(posedge clk) begin
    if (start) begin
      d <= (size == 64'd0) ? 64'd0 : size - 64'd1;
    end
    s2 <= sa3;
    s3 <= sb3 | wcrra_pkg::PAGE_LOW;
  end

  assign res.done = v3;
  assign res.szm1 = s3;

  `WCRRA_ASSERT_IMPLY(a_szm1_page, res.done, &res.szm1[wcrra_pkg::PAGE_BITS-1:0], "size below a page")
  `WCRRA_ASSERT_IMPLY(a_szm1_pow2, res.done, (res.szm1 & (res.szm1 + 64'd1)) == 64'd0, "size not a power of two")

endmodule

`default_nettype wire

// ===== src/wc_range_register_allocator_top.sv =====
// Write-combining range slot allocator. A request is taken when start is high
// and busy is low; its single result appears on status, slot_used and the two
// slot words for exactly one cycle with done high, and must be captured then.
// Requests are handled one at a time. A raw write passes the write state, a
// raw read the read and read-wait states; a rejected add goes straight to the
// result. An accepted add runs a 3-stage size round-up pipeline, then, if
// aligned, a scan reading one slot per cycle from the slot RAMs, then, if none
// matches and one is free, the new slot's write-back. Slot state is cleared at
// reset by per-slot written flags, so the block is ready right after reset.
// The user must write registers via the cfg port only while idle (unenforced).
`default_nettype none
`include "wc_range_register_allocator_top_macros.svh"

module wc_range_register_allocator_top #(
  parameter int MAX_SLOTS = wcrra_pkg::MAX_SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic [63:0] region_base,
  input  wire logic [63:0] region_size,
  input  wire logic [2:0]  slot_index,
  input  wire logic [63:0] raw_base_word,
  input  wire logic [63:0] raw_mask_word,
  output logic             done,
  output logic [2:0]       status,
  output logic [2:0]       slot_used,
  output logic [63:0]      slot_base_word,
  output logic [63:0]      slot_mask_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int NW = (CW > 4) ? CW : 4;

  wcrra_pkg::state_t  state, state_next;
  wcrra_pkg::status_t resp_status;

  logic [3:0]    active_slots;
  logic          wc_supported;
  logic [7:0]    phys_addr_bits;

  logic [63:0]   req_base;
  logic [2:0]    req_idx;
  logic [63:0]   req_raw_base;
  logic [63:0]   req_raw_mask;
  logic [63:0]   szm1;
  logic [CW-1:0] scan_cnt;
  logic          ev_vld;
  logic [AW-1:0] ev_idx;
  logic          have_free;
  logic [AW-1:0] free_idx;
  logic [2:0]    resp_slot;
  logic [63:0]   resp_base;
  logic [63:0]   resp_mask;
  logic [MAX_SLOTS-1:0] wvalid;

  logic          accept;
  logic          unsupported;
  logic          huge;
  logic          misaligned;
  logic [NW-1:0] n_lim;
  logic          scan_issue;
  logic [5:0]    phys_eff;
  logic [63:0]   pmask;
  logic          idx_in_range;
  logic [AW-1:0] req_addr;
  logic [63:0]   ev_base;
  logic [63:0]   ev_mask;
  logic          ev_free;
  logic          ev_match;
  logic          read_sel;
  logic [63:0]   new_base;
  logic [63:0]   new_mask;
  logic          size_start;
  wcrra_pkg::size_res_t size_res;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [63:0]   ram_wr_base;
  logic [63:0]   ram_wr_mask;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [63:0]   ram_rd_base;
  logic [63:0]   ram_rd_mask;

  // Decode the request and the current configuration
  always_comb begin
    accept       = start && !busy;
    unsupported  = !wc_supported || (active_slots == 4'd0);
    huge         = region_size[63] && (|region_size[62:0]);
    misaligned   = |(req_base & size_res.szm1);
    n_lim        = (NW'(active_slots) > NW'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : NW'(active_slots);
    scan_issue   = NW'(scan_cnt) < n_lim;
    idx_in_range = NW'(req_idx) < NW'(MAX_SLOTS);
    req_addr     = AW'(req_idx);
    if (phys_addr_bits < wcrra_pkg::PHYS_MIN || phys_addr_bits > wcrra_pkg::PHYS_MAX) begin
      phys_eff = wcrra_pkg::PHYS_DEFAULT;
    end else begin
      phys_eff = phys_addr_bits[5:0];
    end
    pmask = ((64'd1 << phys_eff) - 64'd1) & ~wcrra_pkg::PAGE_LOW;
  end

  // Examine the slot read in the previous scan cycle
  always_comb begin
    ev_base  = wvalid[ev_idx] ? ram_rd_base : 64'd0;
    ev_mask  = wvalid[ev_idx] ? ram_rd_mask : 64'd0;
    ev_free  = !ev_mask[wcrra_pkg::VALID_POS];
    ev_match = ev_mask[wcrra_pkg::VALID_POS] && (ev_base[7:0] == wcrra_pkg::WC_TYPE) &&
               (((ev_base ^ req_base) & pmask) == 64'd0);
    read_sel = idx_in_range && wvalid[req_addr];
    new_base = (req_base & pmask) | 64'(wcrra_pkg::WC_TYPE);
    new_mask = (~szm1 & pmask) | wcrra_pkg::VALID_MASK;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      wcrra_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            wcrra_pkg::KIND_ADD: begin
              state_next = (unsupported || huge) ? wcrra_pkg::ST_RESP : wcrra_pkg::ST_SIZE;
            end
            wcrra_pkg::KIND_WRITE: state_next = wcrra_pkg::ST_WRITE;
            wcrra_pkg::KIND_READ:  state_next = wcrra_pkg::ST_READ;
            default:               state_next = wcrra_pkg::ST_RESP;
          endcase
        end
      end
      wcrra_pkg::ST_SIZE: begin
        if (size_res.done) begin
          state_next = misaligned ? wcrra_pkg::ST_RESP : wcrra_pkg::ST_SCAN;
        end
      end
      wcrra_pkg::ST_SCAN: begin
        if (ev_vld && ev_match) begin
          state_next = wcrra_pkg::ST_RESP;
        end else if (!ev_vld && !scan_issue) begin
          state_next = have_free ? wcrra_pkg::ST_COMMIT : wcrra_pkg::ST_RESP;
        end
      end
      wcrra_pkg::ST_COMMIT:    state_next = wcrra_pkg::ST_RESP;
      wcrra_pkg::ST_WRITE:     state_next = wcrra_pkg::ST_RESP;
      wcrra_pkg::ST_READ:      state_next = wcrra_pkg::ST_READ_WAIT;
      wcrra_pkg::ST_READ_WAIT: state_next = wcrra_pkg::ST_RESP;
      wcrra_pkg::ST_RESP:      state_next = wcrra_pkg::ST_IDLE;
      default:                 state_next = wcrra_pkg::ST_IDLE;
    endcase
  end

  // Drive handshake, size unit and slot RAM controls
  always_comb begin
    busy        = (state != wcrra_pkg::ST_IDLE);
    done        = (state == wcrra_pkg::ST_RESP);
    cfg_ready   = 1'b1;
    size_start  = (state == wcrra_pkg::ST_IDLE) && (state_next == wcrra_pkg::ST_SIZE);
    ram_wr_en   = 1'b0;
    ram_wr_addr = req_addr;
    ram_wr_base = req_raw_base;
    ram_wr_mask = req_raw_mask;
    ram_rd_en   = 1'b0;
    ram_rd_addr = req_addr;
    unique case (state)
      wcrra_pkg::ST_SCAN: begin
        ram_rd_en   = scan_issue;
        ram_rd_addr = scan_cnt[AW-1:0];
      end
      wcrra_pkg::ST_COMMIT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = free_idx;
        ram_wr_base = new_base;
        ram_wr_mask = new_mask;
      end
      wcrra_pkg::ST_WRITE: ram_wr_en = idx_in_range;
      wcrra_pkg::ST_READ:  ram_rd_en = idx_in_range;
      default: ;
    endcase
  end

  // Update state, written flags and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wcrra_pkg::ST_IDLE;
      wvalid    <= '0;
      ev_vld    <= 1'b0;
      have_free <= 1'b0;
    end else begin
      state  <= state_next;
      ev_vld <= (state == wcrra_pkg::ST_SCAN) && (state_next == wcrra_pkg::ST_SCAN) && scan_issue;
      if (ram_wr_en) begin
        wvalid[ram_wr_addr] <= 1'b1;
      end
      if (state == wcrra_pkg::ST_SIZE) begin
        have_free <= 1'b0;
      end else if (state == wcrra_pkg::ST_SCAN && ev_vld && ev_free) begin
        have_free <= 1'b1;
      end
    end
  end

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots   <= wcrra_pkg::ACTIVE_SLOTS_RESET;
      wc_supported   <= wcrra_pkg::WC_SUPPORTED_RESET;
      phys_addr_bits <= wcrra_pkg::PHYS_ADDR_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wcrra_pkg::CFG_ACTIVE_SLOTS:   active_slots   <= cfg_data[3:0];
        wcrra_pkg::CFG_WC_SUPPORTED:   wc_supported   <= cfg_data[0];
        wcrra_pkg::CFG_PHYS_ADDR_BITS: phys_addr_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold request fields, scan progress and the pending result
  always_ff @(posedge clk) begin
    unique case (state)
      wcrra_pkg::ST_IDLE: begin
        if (accept) begin
          req_base     <= region_base;
          req_idx      <= slot_index;
          req_raw_base <= raw_base_word;
          req_raw_mask <= raw_mask_word;
          resp_slot    <= 3'd0;
          resp_base    <= 64'd0;
          resp_mask    <= 64'd0;
          if (kind == wcrra_pkg::KIND_ADD && !unsupported && huge) begin
            resp_status <= wcrra_pkg::STATUS_TOO_LARGE;
          end else begin
            resp_status <= wcrra_pkg::STATUS_UNSUPPORTED;
          end
        end
      end
      wcrra_pkg::ST_SIZE: begin
        szm1        <= size_res.szm1;
        scan_cnt    <= '0;
        resp_status <= wcrra_pkg::STATUS_MISALIGNED;
      end
      wcrra_pkg::ST_SCAN: begin
        if (scan_issue) begin
          scan_cnt <= CW'(scan_cnt + 1'b1);
        end
        ev_idx <= scan_cnt[AW-1:0];
        if (ev_vld && ev_free && !have_free) begin
          free_idx <= ev_idx;
        end
        resp_status <= (ev_vld && ev_match) ? wcrra_pkg::STATUS_COVERED
                                            : wcrra_pkg::STATUS_NO_FREE;
      end
      wcrra_pkg::ST_COMMIT: begin
        resp_status <= wcrra_pkg::STATUS_ADDED;
        resp_slot   <= 3'(free_idx);
        resp_base   <= new_base;
        resp_mask   <= new_mask;
      end
      wcrra_pkg::ST_WRITE: begin
        resp_status <= wcrra_pkg::STATUS_WRITTEN;
        resp_slot   <= req_idx;
        resp_base   <= idx_in_range ? req_raw_base : 64'd0;
        resp_mask   <= idx_in_range ? req_raw_mask : 64'd0;
      end
      wcrra_pkg::ST_READ_WAIT: begin
        resp_status <= wcrra_pkg::STATUS_READ;
        resp_slot   <= req_idx;
        resp_base   <= read_sel ? ram_rd_base : 64'd0;
        resp_mask   <= read_sel ? ram_rd_mask : 64'd0;
      end
      default: ;
    endcase
  end

  assign status         = resp_status;
  assign slot_used      = resp_slot;
  assign slot_base_word = resp_base;
  assign slot_mask_word = resp_mask;

  wcrra_size_unit u_size (
    .clk   (clk),
    .rst   (rst),
    .start (size_start),
    .size  (region_size),
    .res   (size_res)
  );

  wcrra_ram #(
    .WIDTH (64),
    .DEPTH (MAX_SLOTS)
  ) u_base_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_base),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_base)
  );

  wcrra_ram #(
    .WIDTH (64),
    .DEPTH (MAX_SLOTS)
  ) u_mask_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_mask),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_mask)
  );

  `WCRRA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request left block idle")
  `WCRRA_ASSERT_NEXT(a_done_idle, done, !busy, "block still busy after result")
  `WCRRA_ASSERT_IMPLY(a_added_word, done && status == wcrra_pkg::STATUS_ADDED, slot_mask_word[wcrra_pkg::VALID_POS] && slot_base_word[7:0] == wcrra_pkg::WC_TYPE, "added slot malformed")
  `WCRRA_ASSERT_IMPLY(a_covered_zero, done && status == wcrra_pkg::STATUS_COVERED, slot_used == 3'd0 && slot_base_word == 64'd0 && slot_mask_word == 64'd0, "covered result not zero")

endmodule

`default_nettype wire

// ===== sim/wc_range_register_allocator_checker.sv =====
`timescale 1ns / 1ps

module wc_range_register_allocator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  kind,
  input  logic [63:0] region_base,
  input  logic [63:0] region_size,
  input  logic [2:0]  slot_index,
  input  logic [63:0] raw_base_word,
  input  logic [63:0] raw_mask_word,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [2:0]  slot_used,
  input  logic [63:0] slot_base_word,
  input  logic [63:0] slot_mask_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatch_count,
  output int          pending_count
);
  import wcrra_pkg::*;

  localparam int SLOT_COUNT = MAX_SLOTS_DEFAULT;

  typedef struct {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [63:0] base_word;
    logic [63:0] mask_word;
  } slot_result_t;

  // Shadow copy of the slot table and the register file
  logic [63:0] base_tbl [SLOT_COUNT];
  logic [63:0] mask_tbl [SLOT_COUNT];
  logic [3:0]  active_slots_q;
  logic        wc_supported_q;
  logic [7:0]  phys_bits_q;

  slot_result_t slot_results_q [$];
  int errors = 0;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  // Round the size up, check alignment, scan for a match or a free slot
  function automatic slot_result_t add_region(input logic [63:0] base,
                                              input logic [63:0] size);
    logic [3:0]   n;
    logic [7:0]   phys;
    logic [63:0]  pmask;
    logic [63:0]  sz;
    logic         have_free;
    int           free_slot;
    slot_result_t r;
    r = '{STATUS_UNSUPPORTED, 3'd0, 64'd0, 64'd0};
    n = (active_slots_q > SLOT_COUNT) ? 4'(SLOT_COUNT) : active_slots_q;
    if (!wc_supported_q || n == 4'd0) return r;
    phys = phys_bits_q;
    if (phys < PHYS_MIN || phys > PHYS_MAX) phys = 8'(PHYS_DEFAULT);
    pmask = ((64'd1 << phys) - 64'd1) & ~PAGE_LOW;
    if (size > 64'h8000_0000_0000_0000) begin
      r.status = STATUS_TOO_LARGE;
      return r;
    end
    sz = 64'h1000;
    while (sz < size) sz = sz << 1;
    if ((base & (sz - 64'd1)) != 64'd0) begin
      r.status = STATUS_MISALIGNED;
      return r;
    end
    have_free = 1'b0;
    free_slot = 0;
    for (int i = 0; i < n; i++) begin
      if ((mask_tbl[i] & VALID_MASK) == 64'd0) begin
        if (!have_free) begin
          have_free = 1'b1;
          free_slot = i;
        end
      end else if (base_tbl[i][7:0] == WC_TYPE &&
                   (base_tbl[i] & pmask) == (base & pmask)) begin
        r.status = STATUS_COVERED;
        return r;
      end
    end
    if (!have_free) begin
      r.status = STATUS_NO_FREE;
      return r;
    end
    base_tbl[free_slot] = (base & pmask) | {56'd0, WC_TYPE};
    mask_tbl[free_slot] = (~(sz - 64'd1) & pmask) | VALID_MASK;
    r = '{STATUS_ADDED, 3'(free_slot), base_tbl[free_slot], mask_tbl[free_slot]};
    return r;
  endfunction

  // Work out the one result of a request and update the shadow table
  function automatic slot_result_t predict_request(input logic [1:0]  k,
                                                   input logic [63:0] base,
                                                   input logic [63:0] size,
                                                   input logic [2:0]  idx,
                                                   input logic [63:0] rb,
                                                   input logic [63:0] rm);
    slot_result_t r;
    r = '{STATUS_UNSUPPORTED, 3'd0, 64'd0, 64'd0};
    case (k)
      KIND_ADD: r = add_region(base, size);
      KIND_WRITE: begin
        base_tbl[idx] = rb;
        mask_tbl[idx] = rm;
        r = '{STATUS_WRITTEN, idx, rb, rm};
      end
      KIND_READ: r = '{STATUS_READ, idx, base_tbl[idx], mask_tbl[idx]};
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare results, track register writes, queue predictions
  always @(posedge clk) begin : watch_channels
    slot_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        base_tbl[i] = 64'd0;
        mask_tbl[i] = 64'd0;
      end
      active_slots_q = ACTIVE_SLOTS_RESET;
      wc_supported_q = WC_SUPPORTED_RESET;
      phys_bits_q    = PHYS_ADDR_BITS_RESET;
      slot_results_q.delete();
    end else begin
      if (done) begin
        if (slot_results_q.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d slot %0d",
                   $time, status, slot_used);
          errors++;
        end else begin
          want = slot_results_q.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("slot_used", 64'(want.slot), 64'(slot_used));
          check_field("slot_base_word", want.base_word, slot_base_word);
          check_field("slot_mask_word", want.mask_word, slot_mask_word);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ACTIVE_SLOTS:   active_slots_q = cfg_data[3:0];
          CFG_WC_SUPPORTED:   wc_supported_q = cfg_data[0];
          CFG_PHYS_ADDR_BITS: phys_bits_q    = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        slot_results_q.push_back(predict_request(kind, region_base, region_size,
                                                 slot_index, raw_base_word,
                                                 raw_mask_word));
    end
    mismatch_count <= errors;
    pending_count  <= slot_results_q.size();
  end

endmodule

// ===== sim/wc_range_register_allocator_top_tb.sv =====
`timescale 1ns / 1ps

module wc_range_register_allocator_top_tb;
  import wcrra_pkg::*;

  // Request kind the block does not define; it must answer with zeros
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  kind = KIND_ADD;
  logic [63:0] region_base = 64'd0;
  logic [63:0] region_size = 64'd0;
  logic [2:0]  slot_index = 3'd0;
  logic [63:0] raw_base_word = 64'd0;
  logic [63:0] raw_mask_word = 64'd0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = CFG_ACTIVE_SLOTS;
  logic [7:0]  cfg_data = 8'd0;
  logic        busy;
  logic        done;
  logic [2:0]  status;
  logic [2:0]  slot_used;
  logic [63:0] slot_base_word;
  logic [63:0] slot_mask_word;
  logic        cfg_ready;
  int          mismatch_count;
  int          pending_count;
  logic        gaps_on = 1'b1;

  // Register settings per phase; the last two are drawn at random
  logic [3:0] phase_act  [PHASES] = '{8, 8, 1, 15, 0, 4, 8, 3, 0, 0};
  logic       phase_wc   [PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1, 1, 1};
  logic [7:0] phase_phys [PHASES] = '{36, 52, 32, 31, 40, 53, 255, 0, 0, 0};

  wc_range_register_allocator_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .region_base    (region_base),
    .region_size    (region_size),
    .slot_index     (slot_index),
    .raw_base_word  (raw_base_word),
    .raw_mask_word  (raw_mask_word),
    .done           (done),
    .status         (status),
    .slot_used      (slot_used),
    .slot_base_word (slot_base_word),
    .slot_mask_word (slot_mask_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  wc_range_register_allocator_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .region_base    (region_base),
    .region_size    (region_size),
    .slot_index     (slot_index),
    .raw_base_word  (raw_base_word),
    .raw_mask_word  (raw_mask_word),
    .done           (done),
    .status         (status),
    .slot_used      (slot_used),
    .slot_base_word (slot_base_word),
    .slot_mask_word (slot_mask_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Present one request and hold it until the block takes it
  task automatic send_request(input logic [1:0] k, input logic [63:0] base,
                              input logic [63:0] size, input logic [2:0] idx,
                              input logic [63:0] rb, input logic [63:0] rm);
    kind          <= k;
    region_base   <= base;
    region_size   <= size;
    slot_index    <= idx;
    raw_base_word <= rb;
    raw_mask_word <= rm;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for a random gap, mostly short, sometimes long
  task automatic idle_between();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    gap = 0;
    if (gaps_on && pick >= 50) gap = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every predicted result has come back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_index_t idx, input logic [7:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all three registers; unused upper data bits carry noise
  task automatic apply_settings(input logic [3:0] act, input logic wc,
                                input logic [7:0] phys);
    cfg_write(CFG_ACTIVE_SLOTS, {4'($urandom_range(0, 15)), act});
    cfg_write(CFG_WC_SUPPORTED, {7'($urandom_range(0, 127)), wc});
    cfg_write(CFG_PHYS_ADDR_BITS, phys);
    cfg_valid <= 1'b0;
  endtask

  // Field extremes, every kind and the corner cases of the add path
  task automatic run_directed();
    logic [63:0] ones;
    logic [63:0] other_type;
    ones = '1;
    other_type = 64'h0000_0000_0010_0006;
    send_request(KIND_READ, 64'd0, 64'd0, 3'd0, 64'd0, 64'd0);
    send_request(KIND_ADD, 64'd0, 64'd0, 3'd0, 64'd0, 64'd0);
    send_request(KIND_ADD, 64'd0, 64'h1000, 3'd0, 64'd0, 64'd0);
    // high address bits fall outside the physical mask
    send_request(KIND_ADD, 64'hF000_0000_0000_0000, 64'h1000, 3'd0, 64'd0, 64'd0);
    send_request(KIND_ADD, 64'h2000, 64'h1001, 3'd0, 64'd0, 64'd0);
    send_request(KIND_ADD, 64'h1000, 64'h2000, 3'd0, 64'd0, 64'd0);
    send_request(KIND_ADD, 64'd0, 64'h8000_0000_0000_0001, 3'd0, 64'd0, 64'd0);
    send_request(KIND_ADD, 64'd0, ones, 3'd0, 64'd0, 64'd0);
    send_request(KIND_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                 3'd0, 64'd0, 64'd0);
    send_request(KIND_ADD, ones, 64'd0, 3'd0, 64'd0, 64'd0);
    send_request(KIND_WRITE, 64'd0, 64'd0, 3'd7, ones, ones);
    send_request(KIND_READ, 64'd0, 64'd0, 3'd7, 64'd0, 64'd0);
    send_request(KIND_UNUSED, ones, ones, 3'd7, ones, ones);
    // fill the rest with valid slots of another memory type
    for (int i = 2; i < 7; i++)
      send_request(KIND_WRITE, 64'd0, 64'd0, 3'(i), other_type,
                   64'hFFFF_FFF0_0000_0800);
    // same base as a non write-combining slot is not a match
    send_request(KIND_ADD, 64'h10_0000, 64'h1000, 3'd0, 64'd0, 64'd0);
    send_request(KIND_WRITE, 64'd0, 64'd0, 3'd3, 64'd0, 64'd0);
    send_request(KIND_ADD, 64'h10_0000, 64'h1000, 3'd0, 64'd0, 64'd0);
    send_request(KIND_READ, 64'd0, 64'd0, 3'd3, 64'd0, 64'd0);
    send_request(KIND_READ, 64'd0, 64'd0, 3'd1, 64'd0, 64'd0);
  endtask

  // Mostly aligned adds over a small address pool, plus slot churn and noise
  task automatic send_random_item();
    int          pick;
    int          sub;
    int          s;
    logic [63:0] sz;
    logic [63:0] size;
    logic [63:0] base;
    logic [63:0] rb;
    logic [63:0] rm;
    logic [2:0]  idx;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 3);
    idx  = 3'($urandom_range(0, 7));
    rb   = {$urandom, $urandom};
    rm   = {$urandom, $urandom};
    if (pick < 55) begin
      s  = ($urandom_range(0, 9) < 8) ? $urandom_range(12, 16) : $urandom_range(17, 40);
      sz = 64'd1 << s;
      if (s == 12) size = 64'($urandom_range(0, 4096));
      else size = (sz >> 1) + 64'd1 + ({$urandom, $urandom} & ((sz >> 1) - 64'd1));
      base = 64'($urandom_range(0, 7)) << s;
      if ($urandom_range(0, 3) == 0)
        base = base | ({$urandom, $urandom} & 64'hFFF0_0000_0000_0000);
      if ($urandom_range(0, 4) == 0 && s < 32)
        base = base | ({$urandom, $urandom} & 64'h000F_FFFF_0000_0000);
      send_request(KIND_ADD, base, size, idx, rb, rm);
    end else if (pick < 62) begin
      base = {$urandom, $urandom};
      case (sub)
        0: size = {$urandom, $urandom} | 64'h8000_0000_0000_0001;
        1: begin
          size = 64'h8000_0000_0000_0000;
          base = {$urandom_range(0, 1) == 1, 63'd0};
        end
        2: size = {$urandom, $urandom};
        default: size = 64'd0;
      endcase
      send_request(KIND_ADD, base, size, idx, rb, rm);
    end else if (pick < 78) begin
      // free a slot, plant a write-combining one, or store raw noise
      if (sub < 2) begin
        rm = rm & ~VALID_MASK;
      end else if (sub == 2) begin
        rb = (64'($urandom_range(0, 7)) << $urandom_range(12, 16)) | {56'd0, WC_TYPE};
        rm = rm | VALID_MASK;
      end
      send_request(KIND_WRITE, {$urandom, $urandom}, {$urandom, $urandom}, idx, rb, rm);
    end else if (pick < 96) begin
      send_request(KIND_READ, {$urandom, $urandom}, {$urandom, $urandom}, idx, rb, rm);
    end else begin
      send_request(KIND_UNUSED, {$urandom, $urandom}, {$urandom, $urandom}, idx, rb, rm);
    end
  endtask

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < PHASES; ph++) begin
      // reprogram only once the block has drained
      if (ph > 0) begin
        wait_idle();
        if (ph >= PHASES - 2)
          apply_settings(4'($urandom_range(0, 15)), $urandom_range(0, 3) != 0,
                         8'($urandom_range(0, 255)));
        else
          apply_settings(phase_act[ph], phase_wc[ph], phase_phys[ph]);
      end
      if (ph == 0) run_directed();
      gaps_on = (ph != 2 && ph != 6);
      repeat (ITEMS_PER_PHASE) begin
        send_random_item();
        if ($urandom_range(0, 99) < 3) wait_idle();
        else idle_between();
      end
    end
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== wc_range_register_allocator_top.f =====
+incdir+src
src/wcrra_pkg.sv
src/wcrra_ram.sv
src/wcrra_size_unit.sv
src/wc_range_register_allocator_top.sv
sim/wc_range_register_allocator_checker.sv
sim/wc_range_register_allocator_top_tb.sv
